@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ src/rsapk_pkg.sv @@
// Shared types and constants of the DER RSA public key decoder.
`default_nettype none

package rsapk_pkg;

    localparam logic [7:0] TAG_SEQ       = 8'h30;
    localparam logic [7:0] TAG_INT       = 8'h02;
    localparam logic [7:0] LEN_LONG_MIN  = 8'h80;
    localparam logic [7:0] LEN_LONG1     = 8'h81;
    localparam logic [7:0] LEN_LONG2     = 8'h82;
    localparam logic [7:0] EXP_LEN_MAX   = 8'h7f;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_MOD    = 2'd1,
        KIND_EXP    = 2'd2,
        KIND_IGN    = 2'd3
    } t_kind;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_SEQ_TAG = 4'd1;
    localparam logic [3:0] ST_BAD_SEQ_LEN = 4'd2;
    localparam logic [3:0] ST_BAD_MOD_TAG = 4'd3;
    localparam logic [3:0] ST_BAD_MOD_LEN = 4'd4;
    localparam logic [3:0] ST_BAD_EXP_TAG = 4'd5;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd6;
    localparam logic [3:0] ST_ZERO_LEN    = 4'd7;
    localparam logic [3:0] ST_EXP_LONG    = 4'd8;

    typedef struct packed {
        logic [7:0]  content_byte;
        t_kind       byte_kind;
        logic        done_res;
        logic [3:0]  status;
        logic [15:0] modulus_length;
        logic [7:0]  exponent_length;
        logic [16:0] total_length;
    } t_result;

endpackage

`default_nettype wire

@@ src/rsapk_parser.sv @@
// Parser state machine: per-byte state update and result formation.
`default_nettype none

module rsapk_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_fire,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_frame_start,
    output rsapk_pkg::t_result    o_result
);
    import rsapk_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_SEQ_LEN  = 4'd1,
        PH_SEQ_L1   = 4'd2,
        PH_SEQ_LH   = 4'd3,
        PH_SEQ_LL   = 4'd4,
        PH_MOD_TAG  = 4'd5,
        PH_MOD_LEN  = 4'd6,
        PH_MOD_L1   = 4'd7,
        PH_MOD_LH   = 4'd8,
        PH_MOD_LL   = 4'd9,
        PH_MOD_DATA = 4'd10,
        PH_EXP_TAG  = 4'd11,
        PH_EXP_LEN  = 4'd12,
        PH_EXP_DATA = 4'd13
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_outer_len, n_outer_len;
    logic [1:0]  r_outer_hdr, n_outer_hdr;
    logic [7:0]  r_len_hi,    n_len_hi;
    logic [15:0] r_mod_len,   n_mod_len;
    logic [7:0]  r_exp_len,   n_exp_len;
    logic [15:0] r_remain,    n_remain;
    logic [16:0] r_consumed,  n_consumed;

    t_kind       kind;
    logic        done;
    logic [3:0]  status;
    logic [15:0] remain_dec;
    logic [15:0] len_wide;

    function automatic logic [3:0] final_status(
        input logic [16:0] consumed,
        input logic [15:0] outer_len,
        input logic [1:0]  outer_hdr,
        input logic [15:0] mod_len,
        input logic [7:0]  exp_len
    );
        logic [16:0] expect_len;
        expect_len = {1'b0, outer_len} + {15'd0, outer_hdr} + 17'd1;
        priority if (consumed != expect_len) begin
            return ST_LEN_MISMATCH;
        end else if (mod_len == 16'd0 || exp_len == 8'd0) begin
            return ST_ZERO_LEN;
        end else if (exp_len > EXP_LEN_MAX) begin
            return ST_EXP_LONG;
        end else begin
            return ST_OK;
        end
    endfunction

    assign remain_dec = (r_remain != 16'd0) ? (r_remain - 16'd1) : r_remain;
    assign len_wide   = {r_len_hi, i_data_byte};

    always_comb begin
        n_phase     = r_phase;
        n_outer_len = r_outer_len;
        n_outer_hdr = r_outer_hdr;
        n_len_hi    = r_len_hi;
        n_mod_len   = r_mod_len;
        n_exp_len   = r_exp_len;
        n_remain    = r_remain;
        n_consumed  = r_consumed;
        kind        = KIND_HEADER;
        done        = 1'b0;
        status      = ST_OK;

        if (i_frame_start) begin
            n_outer_len = 16'd0;
            n_outer_hdr = 2'd0;
            n_len_hi    = 8'd0;
            n_mod_len   = 16'd0;
            n_exp_len   = 8'd0;
            n_remain    = 16'd0;
            n_consumed  = 17'd1;
            if (i_data_byte == TAG_SEQ) begin
                n_phase = PH_SEQ_LEN;
            end else begin
                n_phase = PH_IDLE;
                done    = 1'b1;
                status  = ST_BAD_SEQ_TAG;
            end
        end else if (r_phase == PH_IDLE) begin
            kind = KIND_IGN;
        end else begin
            n_consumed = r_consumed + 17'd1;
            unique case (r_phase)
                PH_SEQ_LEN: begin
                    priority if (i_data_byte < LEN_LONG_MIN) begin
                        n_outer_len = {8'd0, i_data_byte};
                        n_outer_hdr = 2'd1;
                        n_phase     = PH_MOD_TAG;
                    end else if (i_data_byte == LEN_LONG1) begin
                        n_outer_hdr = 2'd2;
                        n_phase     = PH_SEQ_L1;
                    end else if (i_data_byte == LEN_LONG2) begin
                        n_outer_hdr = 2'd3;
                        n_phase     = PH_SEQ_LH;
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD_SEQ_LEN;
                    end
                end
                PH_SEQ_L1: begin
                    n_outer_len = {8'd0, i_data_byte};
                    n_phase     = PH_MOD_TAG;
                end
                PH_SEQ_LH: begin
                    n_len_hi = i_data_byte;
                    n_phase  = PH_SEQ_LL;
                end
                PH_SEQ_LL: begin
                    n_outer_len = len_wide;
                    n_phase     = PH_MOD_TAG;
                end
                PH_MOD_TAG: begin
                    if (i_data_byte == TAG_INT) begin
                        n_phase = PH_MOD_LEN;
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD_MOD_TAG;
                    end
                end
                PH_MOD_LEN: begin
                    priority if (i_data_byte < LEN_LONG_MIN) begin
                        n_mod_len = {8'd0, i_data_byte};
                        n_remain  = {8'd0, i_data_byte};
                        n_phase   = (i_data_byte == 8'd0) ? PH_EXP_TAG : PH_MOD_DATA;
                    end else if (i_data_byte == LEN_LONG1) begin
                        n_phase = PH_MOD_L1;
                    end else if (i_data_byte == LEN_LONG2) begin
                        n_phase = PH_MOD_LH;
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD_MOD_LEN;
                    end
                end
                PH_MOD_L1: begin
                    n_mod_len = {8'd0, i_data_byte};
                    n_remain  = {8'd0, i_data_byte};
                    n_phase   = (i_data_byte == 8'd0) ? PH_EXP_TAG : PH_MOD_DATA;
                end
                PH_MOD_LH: begin
                    n_len_hi = i_data_byte;
                    n_phase  = PH_MOD_LL;
                end
                PH_MOD_LL: begin
                    n_mod_len = len_wide;
                    n_remain  = len_wide;
                    n_phase   = (len_wide == 16'd0) ? PH_EXP_TAG : PH_MOD_DATA;
                end
                PH_MOD_DATA: begin
                    kind     = KIND_MOD;
                    n_remain = remain_dec;
                    if (remain_dec == 16'd0) begin
                        n_phase = PH_EXP_TAG;
                    end
                end
                PH_EXP_TAG: begin
                    if (i_data_byte == TAG_INT) begin
                        n_phase = PH_EXP_LEN;
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD_EXP_TAG;
                    end
                end
                PH_EXP_LEN: begin
                    n_exp_len = i_data_byte;
                    n_remain  = {8'd0, i_data_byte};
                    if (i_data_byte == 8'd0) begin
                        done   = 1'b1;
                        status = final_status(n_consumed, r_outer_len, r_outer_hdr,
                                              r_mod_len, i_data_byte);
                    end else begin
                        n_phase = PH_EXP_DATA;
                    end
                end
                PH_EXP_DATA: begin
                    kind     = KIND_EXP;
                    n_remain = remain_dec;
                    if (remain_dec == 16'd0) begin
                        done   = 1'b1;
                        status = final_status(n_consumed, r_outer_len, r_outer_hdr,
                                              r_mod_len, r_exp_len);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            if (done) begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        o_result.content_byte    = i_data_byte;
        o_result.byte_kind       = kind;
        o_result.done_res        = done;
        o_result.status          = status;
        o_result.modulus_length  = n_mod_len;
        o_result.exponent_length = n_exp_len;
        o_result.total_length    = n_consumed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_outer_len <= 16'd0;
            r_outer_hdr <= 2'd0;
            r_len_hi    <= 8'd0;
            r_mod_len   <= 16'd0;
            r_exp_len   <= 8'd0;
            r_remain    <= 16'd0;
            r_consumed  <= 17'd0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_outer_len <= n_outer_len;
            r_outer_hdr <= n_outer_hdr;
            r_len_hi    <= n_len_hi;
            r_mod_len   <= n_mod_len;
            r_exp_len   <= n_exp_len;
            r_remain    <= n_remain;
            r_consumed  <= n_consumed;
        end
    end

endmodule

`default_nettype wire

@@ src/der_rsa_pubkey_decoder.sv @@
// Top level of the DER RSA public key decoder: input register, parser, result register.
//
// Usage:
//   Input channel: i_valid / o_ready with i_data_byte and i_frame_start. Send the
//   DER bytes of one key in order; raise i_frame_start with the SEQUENCE tag byte.
//   Output channel: o_valid / i_ready. Every accepted byte yields exactly one
//   result: the byte itself, its kind (header, modulus, exponent, ignored), the
//   decoded lengths, the byte count so far, a done flag and a status code.
//   Path: an accepted byte waits in the input register; when it advances, its
//   result is written into the result register, from which it can be taken.
//   Throughput: one byte per cycle while i_ready is high, set by the parser state
//   update logic, combinational between the input register and the result register.
//   Reset (i_rst_n low, synchronous): both registers empty, parser idle; bytes
//   without i_frame_start are then passed through as ignored.
//   Receiver stall: the result holds in the output register while the next byte
//   waits in the input register; o_ready drops only when both are full and
//   i_ready is low.
`default_nettype none

`include "assert_macros.svh"

module der_rsa_pubkey_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_frame_start,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_content_byte,
    output logic [1:0]  o_byte_kind,
    output logic        o_done_res,
    output logic [3:0]  o_status,
    output logic [15:0] o_modulus_length,
    output logic [7:0]  o_exponent_length,
    output logic [16:0] o_total_length
);
    import rsapk_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_start;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    rsapk_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_data_byte   (r_in_data),
        .i_frame_start (r_in_start),
        .o_result      (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_data  <= i_data_byte;
            r_in_start <= i_frame_start;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_content_byte    = r_out.content_byte;
    assign o_byte_kind       = r_out.byte_kind;
    assign o_done_res        = r_out.done_res;
    assign o_status          = r_out.status;
    assign o_modulus_length  = r_out.modulus_length;
    assign o_exponent_length = r_out.exponent_length;
    assign o_total_length    = r_out.total_length;

    `ASSERT_PROP(a_status_only_when_done, i_clk, i_rst_n,
                 (o_valid && !o_done_res) |-> (o_status == ST_OK))
    `ASSERT_NEVER(a_ignored_not_done, i_clk, i_rst_n,
                  o_valid && (o_byte_kind == KIND_IGN) && o_done_res)
    `ASSERT_NEVER(a_status_in_range, i_clk, i_rst_n, o_valid && (o_status > ST_EXP_LONG))
    `ASSERT_PROP(a_full_stall_blocks, i_clk, i_rst_n,
                 (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)

endmodule

`default_nettype wire
